// File: hdl/ljpf_pkg.sv
// Shared types and constants for the Lennard-Jones pair force pipeline.
// Used by ljpf_image_sel, ljpf_recip and lennard_jones_pair_force; no dependencies.
package ljpf_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_SQ   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_SHIFT = 2'd2;

    localparam logic [31:0]        BOX_LENGTH_RST  = 32'd360000000;
    localparam logic [31:0]        CUTOFF_SQ_RST   = 32'd6553600;
    localparam logic signed [31:0] FORCE_SHIFT_RST = -32'sd2556;

    // pipeline shape
    localparam int IMG_STAGES = 4;
    localparam int SQ_STAGES  = 8;
    localparam int SQ_STEPS   = 4;
    localparam int DV_STAGES  = 15;
    localparam int DV_STEPS   = 4;
    localparam int INV_STEPS  = 57;
    localparam int U_STEPS    = 31;
    localparam int POW_MULS   = 5;

    // powers are clipped at 2^56
    localparam logic [56:0] PWR_MAX     = {1'b1, 56'd0};
    localparam logic [31:0] OUT_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] OUT_MIN_MAG = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] first_x;
        logic [31:0] first_y;
        logic [31:0] first_z;
        logic [31:0] second_x;
        logic [31:0] second_y;
        logic [31:0] second_z;
    } ljpf_in_t;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               in_range;
        logic               saturated;
    } ljpf_out_t;

    // chosen image: squared distance and separation per axis (index 0 = x)
    typedef struct packed {
        logic             hit;
        logic [63:0]      r2;
        logic [2:0]       dneg;
        logic [2:0][31:0] dmag;
    } ljpf_sel_t;

    // distance reciprocal and unit vector
    typedef struct packed {
        logic             hit;
        logic             rzero;
        logic             rsmall;
        logic [56:0]      inv;
        logic [2:0][30:0] u;
        logic [2:0]       dneg;
        logic [2:0]       dnz;
    } ljpf_rcp_t;

endpackage

// File: hdl/ljpf_image_sel.sv
// Periodic image search: four stages from positions to the first image inside the cutoff.
// Depends on ljpf_pkg.
module ljpf_image_sel (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  ljpf_pkg::ljpf_in_t in_item,
    input  logic [31:0]       box_length,
    input  logic [31:0]       cutoff_sq,
    output logic              out_valid,
    output ljpf_pkg::ljpf_sel_t out_sel
);
    import ljpf_pkg::*;

    logic [2:0][31:0] first_c;
    logic [2:0][31:0] second_c;

    logic [2:0][2:0]        s1_neg_next, s1_neg_reg;
    logic [2:0][2:0][31:0]  s1_mag_next, s1_mag_reg;
    logic [2:0][2:0]        s1_far_next, s1_far_reg;

    logic [2:0][2:0][63:0]  s2_sq_next, s2_sq_reg;
    logic [2:0][2:0]        s2_neg_reg, s2_far_reg;
    logic [2:0][2:0][31:0]  s2_mag_reg;

    logic [26:0]            s3_hit_next, s3_hit_reg;
    logic [2:0][2:0][63:0]  s3_sq_reg;
    logic [2:0][2:0]        s3_neg_reg;
    logic [2:0][2:0][31:0]  s3_mag_reg;

    ljpf_sel_t              sel_next, sel_reg;
    logic [IMG_STAGES-1:0]  v_reg;

    assign first_c  = {in_item.first_z, in_item.first_y, in_item.first_x};
    assign second_c = {in_item.second_z, in_item.second_y, in_item.second_x};

    // stage 1: separation for offsets +L, 0, -L on each axis
    always_comb
    begin
        logic [32:0] base;
        logic [34:0] bx;
        logic [34:0] lx;
        logic [34:0] tk;
        logic [34:0] mk;
        s1_neg_next = '0;
        s1_mag_next = '0;
        s1_far_next = '0;
        lx = {3'b000, box_length};
        for (int a = 0; a < 3; a++)
        begin
            base = {1'b0, first_c[a]} - {1'b0, second_c[a]};
            bx   = {{2{base[32]}}, base};
            for (int k = 0; k < 3; k++)
            begin
                case (k)
                    0:       tk = bx + lx;
                    1:       tk = bx;
                    default: tk = bx - lx;
                endcase
                mk = tk[34] ? (~tk + 35'd1) : tk;
                s1_neg_next[a][k] = tk[34];
                s1_mag_next[a][k] = mk[31:0];
                s1_far_next[a][k] = |mk[34:32];
            end
        end
    end

    // stage 2: squares
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s2_sq_next[a][k] = 64'(s1_mag_reg[a][k]) * 64'(s1_mag_reg[a][k]);
            end
        end
    end

    // stage 3: cutoff test for all 27 images
    always_comb
    begin
        logic [65:0] sum;
        logic [65:0] thr;
        thr = {2'b00, cutoff_sq, 32'd0};
        s3_hit_next = '0;
        for (int kx = 0; kx < 3; kx++)
        begin
            for (int ky = 0; ky < 3; ky++)
            begin
                for (int kz = 0; kz < 3; kz++)
                begin
                    sum = 66'(s2_sq_reg[0][kx]) + 66'(s2_sq_reg[1][ky]) + 66'(s2_sq_reg[2][kz]);
                    s3_hit_next[kx*9 + ky*3 + kz] = !(s2_far_reg[0][kx] | s2_far_reg[1][ky]
                                                      | s2_far_reg[2][kz]) && (sum < thr);
                end
            end
        end
    end

    // stage 4: first hit in x, y, z loop order
    always_comb
    begin
        logic [1:0] sx;
        logic [1:0] sy;
        logic [1:0] sz;
        sx = '0;
        sy = '0;
        sz = '0;
        for (int kx = 2; kx >= 0; kx--)
        begin
            for (int ky = 2; ky >= 0; ky--)
            begin
                for (int kz = 2; kz >= 0; kz--)
                begin
                    if (s3_hit_reg[kx*9 + ky*3 + kz])
                    begin
                        sx = 2'(kx);
                        sy = 2'(ky);
                        sz = 2'(kz);
                    end
                end
            end
        end
        sel_next.hit     = |s3_hit_reg;
        sel_next.r2      = s3_sq_reg[0][sx] + s3_sq_reg[1][sy] + s3_sq_reg[2][sz];
        sel_next.dneg[0] = s3_neg_reg[0][sx];
        sel_next.dneg[1] = s3_neg_reg[1][sy];
        sel_next.dneg[2] = s3_neg_reg[2][sz];
        sel_next.dmag[0] = s3_mag_reg[0][sx];
        sel_next.dmag[1] = s3_mag_reg[1][sy];
        sel_next.dmag[2] = s3_mag_reg[2][sz];
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[IMG_STAGES-2:0], in_valid};
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_neg_reg <= s1_neg_next;
            s1_mag_reg <= s1_mag_next;
            s1_far_reg <= s1_far_next;
            s2_sq_reg  <= s2_sq_next;
            s2_neg_reg <= s1_neg_reg;
            s2_mag_reg <= s1_mag_reg;
            s2_far_reg <= s1_far_reg;
            s3_hit_reg <= s3_hit_next;
            s3_sq_reg  <= s2_sq_reg;
            s3_neg_reg <= s2_neg_reg;
            s3_mag_reg <= s2_mag_reg;
            sel_reg    <= sel_next;
        end
    end

    assign out_valid = v_reg[IMG_STAGES-1];
    assign out_sel   = sel_reg;

endmodule

// File: hdl/ljpf_recip.sv
// Pipelined integer square root followed by four restoring dividers:
// the reciprocal 2^58/r and the unit vector |d|*2^30/r. Depends on ljpf_pkg.
module ljpf_recip (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  ljpf_pkg::ljpf_sel_t in_sel,
    output logic                out_valid,
    output ljpf_pkg::ljpf_rcp_t out_rcp
);
    import ljpf_pkg::*;

    typedef struct packed {
        logic [63:0]      x;
        logic [33:0]      rem;
        logic [31:0]      res;
        logic             hit;
        logic [2:0]       dneg;
        logic [2:0][31:0] dmag;
    } sqrt_st_t;

    // lane 0 is the reciprocal, lanes 1..3 the unit vector axes
    typedef struct packed {
        logic [3:0][32:0] p;
        logic [3:0][56:0] q;
        logic [31:0]      r;
        logic             hit;
        logic             rzero;
        logic             rsmall;
        logic [2:0]       dneg;
        logic [2:0]       dnz;
    } div_st_t;

    sqrt_st_t sq_src   [SQ_STAGES];
    sqrt_st_t sq_next  [SQ_STAGES];
    sqrt_st_t sq_reg   [SQ_STAGES];
    logic     sq_v_src [SQ_STAGES];
    logic     sq_v_reg [SQ_STAGES];

    div_st_t  dv_src   [DV_STAGES];
    div_st_t  dv_next  [DV_STAGES];
    div_st_t  dv_reg   [DV_STAGES];
    logic     dv_v_src [DV_STAGES];
    logic     dv_v_reg [DV_STAGES];

    sqrt_st_t sq_init;
    div_st_t  dv_init;
    sqrt_st_t sq_last;

    // square root start: two radicand bits per step
    always_comb
    begin
        sq_init.x    = in_sel.r2;
        sq_init.rem  = '0;
        sq_init.res  = '0;
        sq_init.hit  = in_sel.hit;
        sq_init.dneg = in_sel.dneg;
        sq_init.dmag = in_sel.dmag;
    end

    for (genvar s = 0; s < SQ_STAGES; s++)
    begin : g_sqrt
        if (s == 0)
        begin : g_head
            assign sq_src[s]   = sq_init;
            assign sq_v_src[s] = in_valid;
        end
        else
        begin : g_body
            assign sq_src[s]   = sq_reg[s-1];
            assign sq_v_src[s] = sq_v_reg[s-1];
        end

        always_comb
        begin
            sqrt_st_t    st;
            logic [35:0] acc;
            logic [35:0] trial;
            st = sq_src[s];
            for (int j = 0; j < SQ_STEPS; j++)
            begin
                acc   = {st.rem, st.x[63:62]};
                trial = {2'b00, st.res, 2'b01};
                st.x  = st.x << 2;
                if (acc >= trial)
                begin
                    acc    = acc - trial;
                    st.res = {st.res[30:0], 1'b1};
                end
                else
                begin
                    st.res = {st.res[30:0], 1'b0};
                end
                st.rem = acc[33:0];
            end
            sq_next[s] = st;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                sq_v_reg[s] <= sq_v_src[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_reg[s] <= sq_next[s];
            end
        end
    end

    // divider start; partial remainder already holds the top numerator bits
    assign sq_last = sq_reg[SQ_STAGES-1];

    always_comb
    begin
        dv_init.p[0]  = 33'd4;
        dv_init.q     = '0;
        dv_init.r     = sq_last.res;
        dv_init.hit   = sq_last.hit;
        dv_init.rzero = (sq_last.res == 32'd0);
        dv_init.rsmall = (sq_last.res < 32'd4);
        dv_init.dneg  = sq_last.dneg;
        for (int l = 0; l < 3; l++)
        begin
            dv_init.p[l+1] = {1'b0, sq_last.dmag[l]};
            dv_init.dnz[l] = (sq_last.dmag[l] != 32'd0);
        end
    end

    for (genvar s = 0; s < DV_STAGES; s++)
    begin : g_div
        if (s == 0)
        begin : g_head
            assign dv_src[s]   = dv_init;
            assign dv_v_src[s] = sq_v_reg[SQ_STAGES-1];
        end
        else
        begin : g_body
            assign dv_src[s]   = dv_reg[s-1];
            assign dv_v_src[s] = dv_v_reg[s-1];
        end

        always_comb
        begin
            div_st_t st;
            st = dv_src[s];
            for (int j = 0; j < DV_STEPS; j++)
            begin
                for (int l = 0; l < 4; l++)
                begin
                    if ((s*DV_STEPS + j) < ((l == 0) ? INV_STEPS : U_STEPS))
                    begin
                        if (st.p[l] >= {1'b0, st.r})
                        begin
                            st.p[l] = st.p[l] - {1'b0, st.r};
                            st.q[l] = {st.q[l][55:0], 1'b1};
                        end
                        else
                        begin
                            st.q[l] = {st.q[l][55:0], 1'b0};
                        end
                        st.p[l] = st.p[l] << 1;
                    end
                end
            end
            dv_next[s] = st;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                dv_v_reg[s] <= dv_v_src[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[s] <= dv_next[s];
            end
        end
    end

    // results; a radius below 4 clips the reciprocal
    always_comb
    begin
        out_rcp.hit    = dv_reg[DV_STAGES-1].hit;
        out_rcp.rzero  = dv_reg[DV_STAGES-1].rzero;
        out_rcp.rsmall = dv_reg[DV_STAGES-1].rsmall;
        out_rcp.inv    = dv_reg[DV_STAGES-1].rsmall ? PWR_MAX : dv_reg[DV_STAGES-1].q[0];
        out_rcp.dneg   = dv_reg[DV_STAGES-1].dneg;
        out_rcp.dnz    = dv_reg[DV_STAGES-1].dnz;
        for (int l = 0; l < 3; l++)
        begin
            out_rcp.u[l] = dv_reg[DV_STAGES-1].q[l+1][30:0];
        end
    end

    assign out_valid = dv_v_reg[DV_STAGES-1];

endmodule

// File: hdl/lennard_jones_pair_force.sv
// Lennard-Jones 12-6 shifted-force pair kernel with periodic minimum image.
// Sustains one item per cycle while the output skid entry is empty.
// The pipeline includes the square root (8 stages), the 57-step divider (15 stages)
// and five chained power multiplies of two stages each.
// Reset clears all valid bits and loads the register defaults; the block is ready at once.
// One-entry skid on the output; pair_stall is high only while that entry is held.
module lennard_jones_pair_force (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pair_valid,
    output logic                                 pair_stall,
    input  ljpf_pkg::ljpf_in_t                   pair,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output ljpf_pkg::ljpf_out_t                  result,
    input  logic                                 cfg_we,
    input  logic [ljpf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                          cfg_data
);
    import ljpf_pkg::*;

    typedef struct packed {
        logic             hit;
        logic             rzero;
        logic             ovf;
        logic [2:0]       dneg;
        logic [2:0]       dnz;
        logic [2:0][30:0] u;
        logic [5:0][56:0] pw;
    } pw_st_t;

    typedef struct packed {
        logic             hit;
        logic             rzero;
        logic             ovf;
        logic [2:0]       dneg;
        logic [2:0]       dnz;
        logic [2:0][30:0] u;
        logic             mneg;
        logic [61:0]      mabs;
    } mg_st_t;

    typedef struct packed {
        logic             hit;
        logic             rzero;
        logic             ovf;
        logic [2:0]       dneg;
        logic [2:0]       dnz;
        logic             mneg;
        logic [2:0][62:0] pl;
        logic [2:0][60:0] ph;
    } ca_st_t;

    // power slots: 0 inv, 1 p2, 2 p4, 3 p6, 4 p7, 5 p13; multiply m writes slot m+1
    localparam int OP_A [POW_MULS] = '{0, 1, 2, 3, 3};
    localparam int OP_B [POW_MULS] = '{0, 1, 1, 0, 4};

    logic [31:0]        box_length_reg;
    logic [31:0]        cutoff_sq_reg;
    logic signed [31:0] force_shift_reg;

    logic               adv;
    logic               sel_valid;
    ljpf_sel_t          sel;
    logic               rcp_valid;
    ljpf_rcp_t          rcp;
    pw_st_t             rcp_pw;

    pw_st_t             pa_reg   [POW_MULS];
    logic               pa_v_reg [POW_MULS];
    logic [63:0]        ll_reg   [POW_MULS];
    logic [56:0]        lh_reg   [POW_MULS];
    logic [56:0]        hl_reg   [POW_MULS];
    logic [49:0]        hh_reg   [POW_MULS];
    pw_st_t             pb_next  [POW_MULS];
    pw_st_t             pb_reg   [POW_MULS];
    logic               pb_v_reg [POW_MULS];

    mg_st_t             mg_next, mg_reg;
    logic               mg_v_reg;
    ca_st_t             ca_next, ca_reg;
    logic               ca_v_reg;
    ljpf_out_t          out_next, out_reg;
    logic               out_v_reg;
    ljpf_out_t          skid_reg;
    logic               skid_valid_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_length_reg  <= BOX_LENGTH_RST;
            cutoff_sq_reg   <= CUTOFF_SQ_RST;
            force_shift_reg <= FORCE_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BOX_LENGTH:  box_length_reg  <= cfg_data;
                CFG_CUTOFF_SQ:   cutoff_sq_reg   <= cfg_data;
                CFG_FORCE_SHIFT: force_shift_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // whole pipeline moves together unless the skid entry is occupied
    assign adv        = !skid_valid_reg;
    assign pair_stall = skid_valid_reg;

    ljpf_image_sel u_image_sel (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (pair_valid),
        .in_item    (pair),
        .box_length (box_length_reg),
        .cutoff_sq  (cutoff_sq_reg),
        .out_valid  (sel_valid),
        .out_sel    (sel)
    );

    ljpf_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sel_valid),
        .in_sel    (sel),
        .out_valid (rcp_valid),
        .out_rcp   (rcp)
    );

    always_comb
    begin
        rcp_pw       = '0;
        rcp_pw.hit   = rcp.hit;
        rcp_pw.rzero = rcp.rzero;
        rcp_pw.ovf   = rcp.rsmall;
        rcp_pw.dneg  = rcp.dneg;
        rcp_pw.dnz   = rcp.dnz;
        rcp_pw.u     = rcp.u;
        rcp_pw.pw[0] = rcp.inv;
    end

    // power chain: partial products, then sum, truncate and clip
    for (genvar m = 0; m < POW_MULS; m++)
    begin : g_pow
        pw_st_t      src;
        logic        src_v;
        logic [56:0] opa;
        logic [56:0] opb;

        if (m == 0)
        begin : g_head
            assign src   = rcp_pw;
            assign src_v = rcp_valid;
        end
        else
        begin : g_body
            assign src   = pb_reg[m-1];
            assign src_v = pb_v_reg[m-1];
        end

        assign opa = src.pw[OP_A[m]];
        assign opb = src.pw[OP_B[m]];

        always_comb
        begin
            logic [113:0] prod;
            logic [81:0]  v;
            logic         clip;
            pb_next[m] = pa_reg[m];
            prod = 114'(ll_reg[m]) + (114'(lh_reg[m]) << 32) + (114'(hl_reg[m]) << 32)
                   + (114'(hh_reg[m]) << 64);
            v    = prod[113:32];
            clip = (v > 82'(PWR_MAX));
            pb_next[m].pw[m+1] = clip ? PWR_MAX : v[56:0];
            pb_next[m].ovf     = pa_reg[m].ovf | clip;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pa_v_reg[m] <= 1'b0;
                pb_v_reg[m] <= 1'b0;
            end
            else if (adv)
            begin
                pa_v_reg[m] <= src_v;
                pb_v_reg[m] <= pa_v_reg[m];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pa_reg[m] <= src;
                ll_reg[m] <= 64'(opa[31:0]) * 64'(opb[31:0]);
                lh_reg[m] <= 57'(opa[31:0]) * 57'(opb[56:32]);
                hl_reg[m] <= 57'(opa[56:32]) * 57'(opb[31:0]);
                hh_reg[m] <= 50'(opa[56:32]) * 50'(opb[56:32]);
                pb_reg[m] <= pb_next[m];
            end
        end
    end

    // magnitude 48*p13 - 24*p7 + shift*2^16, sign and absolute value
    always_comb
    begin
        logic [63:0] p13;
        logic [63:0] p7;
        logic [63:0] sh;
        logic [63:0] big;
        p13 = 64'(pb_reg[POW_MULS-1].pw[5]);
        p7  = 64'(pb_reg[POW_MULS-1].pw[4]);
        sh  = {{32{force_shift_reg[31]}}, force_shift_reg};
        big = (p13 << 5) + (p13 << 4) - (p7 << 4) - (p7 << 3) + (sh << 16);
        mg_next.hit   = pb_reg[POW_MULS-1].hit;
        mg_next.rzero = pb_reg[POW_MULS-1].rzero;
        mg_next.ovf   = pb_reg[POW_MULS-1].ovf;
        mg_next.dneg  = pb_reg[POW_MULS-1].dneg;
        mg_next.dnz   = pb_reg[POW_MULS-1].dnz;
        mg_next.u     = pb_reg[POW_MULS-1].u;
        mg_next.mneg  = big[63];
        mg_next.mabs  = big[63] ? 62'(~big + 64'd1) : big[61:0];
    end

    // component products, split into the low 32 bits and high 30 bits of the magnitude
    always_comb
    begin
        ca_next.hit   = mg_reg.hit;
        ca_next.rzero = mg_reg.rzero;
        ca_next.ovf   = mg_reg.ovf;
        ca_next.dneg  = mg_reg.dneg;
        ca_next.dnz   = mg_reg.dnz;
        ca_next.mneg  = mg_reg.mneg;
        for (int a = 0; a < 3; a++)
        begin
            ca_next.pl[a] = 63'(mg_reg.mabs[31:0]) * 63'(mg_reg.u[a]);
            ca_next.ph[a] = 61'(mg_reg.mabs[61:32]) * 61'(mg_reg.u[a]);
        end
    end

    // final scaling, saturation and special cases
    always_comb
    begin
        logic [92:0]      prod;
        logic [46:0]      v;
        logic [46:0]      lim;
        logic             neg;
        logic             sat;
        logic [2:0][31:0] comp;
        sat  = 1'b0;
        comp = '0;
        for (int a = 0; a < 3; a++)
        begin
            neg  = ca_reg.mneg ^ ca_reg.dneg[a];
            prod = 93'(ca_reg.pl[a]) + (93'(ca_reg.ph[a]) << 32);
            v    = prod[92:46];
            lim  = neg ? 47'(OUT_MIN_MAG) : 47'(OUT_MAX);
            if (v > lim)
            begin
                v   = lim;
                sat = 1'b1;
            end
            comp[a] = neg ? (~v[31:0] + 32'd1) : v[31:0];
        end
        if (!ca_reg.hit || ca_reg.rzero)
        begin
            comp = '0;
            sat  = 1'b0;
        end
        else if (ca_reg.ovf)
        begin
            // huge repulsion: full scale along the sign of each separation
            sat = |ca_reg.dnz;
            for (int a = 0; a < 3; a++)
            begin
                if (!ca_reg.dnz[a])
                begin
                    comp[a] = '0;
                end
                else
                begin
                    comp[a] = ca_reg.dneg[a] ? OUT_MIN_MAG : OUT_MAX;
                end
            end
        end
        out_next.force_x   = comp[0];
        out_next.force_y   = comp[1];
        out_next.force_z   = comp[2];
        out_next.in_range  = ca_reg.hit;
        out_next.saturated = sat;
    end

    // tail valid bits and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mg_v_reg       <= 1'b0;
            ca_v_reg       <= 1'b0;
            out_v_reg      <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                mg_v_reg  <= pb_v_reg[POW_MULS-1];
                ca_v_reg  <= mg_v_reg;
                out_v_reg <= ca_v_reg;
            end
            if (skid_valid_reg)
            begin
                if (!result_stall)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (out_v_reg && result_stall)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mg_reg  <= mg_next;
            ca_reg  <= ca_next;
            out_reg <= out_next;
        end
        if (!skid_valid_reg && out_v_reg && result_stall)
        begin
            skid_reg <= out_reg;
        end
    end

    assign result_valid = skid_valid_reg | out_v_reg;
    assign result       = skid_valid_reg ? skid_reg : out_reg;

endmodule
